/* hw/rtl/lfd_pkg.sv */
// lfd_pkg: shared types and codes for the lrc frame deframer
// no dependencies; used by the parser, the output queue and the top level
`timescale 1ns / 1ps

package lfd_pkg;

  // parser phase codes
  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_MODULE  = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_TAIL    = 3'd5;

  // result kind codes
  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_OK      = 3'd1;
  localparam logic [2:0] KIND_LEN_ERR = 3'd2;
  localparam logic [2:0] KIND_LRC_ERR = 3'd3;
  localparam logic [2:0] KIND_END_ERR = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_HEAD_VALUE  = 2'd0;
  localparam logic [1:0] REG_TAIL_VALUE  = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0] HEAD_RESET = 8'hA5;
  localparam logic [7:0] TAIL_RESET = 8'h5A;
  localparam logic [7:0] MAX_RESET  = 8'd255;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] head_value;
    logic [7:0] tail_value;
    logic [7:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  module_id;
    logic [31:0] frame_length;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t result;
  } push_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } queue_status_t;

endpackage

/* hw/rtl/lfd_stream_if.sv */
// lfd_in_if, lfd_out_if: valid/ready channels for received bytes and results
// no dependencies; the result fields are declared here with their own widths
`timescale 1ns / 1ps

interface lfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  module_id;
  logic [31:0] frame_length;

  modport source (output valid, output out_kind, output out_byte, output module_id,
                  output frame_length, input ready);
  modport sink (input valid, input out_kind, input out_byte, input module_id,
                input frame_length, output ready);
endinterface

/* hw/rtl/lfd_parser.sv */
// lfd_parser: frame state registers and the per-byte update and result logic
// depends on lfd_pkg
`timescale 1ns / 1ps

module lfd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  lfd_pkg::cfg_t  cfg,
  output lfd_pkg::push_t push_o
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  module_r, module_nxt;
  logic [31:0] length_r, length_nxt;
  logic [1:0]  len_cnt_r, len_cnt_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [7:0]  lrc_r, lrc_nxt;
  logic        emit;
  logic [2:0]  kind;
  logic [7:0]  obyte;
  logic [31:0] len_shifted;
  logic [8:0]  pay_cnt_inc;

  always_comb begin
    unique case (len_cnt_r)
      2'd0: len_shifted = {24'd0, rx_byte};
      2'd1: len_shifted = {16'd0, rx_byte, 8'd0};
      2'd2: len_shifted = {8'd0, rx_byte, 16'd0};
      2'd3: len_shifted = {rx_byte, 24'd0};
      default: len_shifted = 32'd0;
    endcase
  end

  assign pay_cnt_inc = {1'b0, pay_cnt_r} + 9'd1;

  always_comb begin
    phase_nxt   = phase_r;
    module_nxt  = module_r;
    length_nxt  = length_r;
    len_cnt_nxt = len_cnt_r;
    pay_cnt_nxt = pay_cnt_r;
    lrc_nxt     = lrc_r;
    emit        = 1'b0;
    kind        = lfd_pkg::KIND_DATA;
    obyte       = 8'd0;
    unique case (phase_r)
      lfd_pkg::PH_WAIT: begin
        if (rx_byte == cfg.head_value) begin
          length_nxt  = 32'd0;
          len_cnt_nxt = 2'd0;
          pay_cnt_nxt = 8'd0;
          lrc_nxt     = 8'd0;
          phase_nxt   = lfd_pkg::PH_MODULE;
        end
      end
      lfd_pkg::PH_MODULE: begin
        module_nxt = rx_byte;
        phase_nxt  = lfd_pkg::PH_LENGTH;
      end
      lfd_pkg::PH_LENGTH: begin
        length_nxt  = length_r | len_shifted;
        len_cnt_nxt = len_cnt_r + 2'd1;
        if (len_cnt_r == 2'd3) begin
          // empty payload skips straight to the lrc byte
          phase_nxt = (length_nxt == 32'd0) ? lfd_pkg::PH_CHECK : lfd_pkg::PH_PAYLOAD;
        end
      end
      lfd_pkg::PH_PAYLOAD: begin
        emit = 1'b1;
        if (pay_cnt_r == 8'd0 && length_r > {24'd0, cfg.max_payload}) begin
          kind      = lfd_pkg::KIND_LEN_ERR;
          phase_nxt = lfd_pkg::PH_WAIT;
        end else begin
          lrc_nxt = lrc_r ^ rx_byte;
          obyte   = rx_byte;
          if ({23'd0, pay_cnt_inc} >= length_r) begin
            pay_cnt_nxt = 8'd0;
            phase_nxt   = lfd_pkg::PH_CHECK;
          end else begin
            pay_cnt_nxt = pay_cnt_inc[7:0];
          end
        end
      end
      lfd_pkg::PH_CHECK: begin
        if (rx_byte != lrc_r) begin
          emit      = 1'b1;
          kind      = lfd_pkg::KIND_LRC_ERR;
          phase_nxt = lfd_pkg::PH_WAIT;
        end else begin
          phase_nxt = lfd_pkg::PH_TAIL;
        end
      end
      lfd_pkg::PH_TAIL: begin
        emit      = 1'b1;
        kind      = (rx_byte == cfg.tail_value) ? lfd_pkg::KIND_OK : lfd_pkg::KIND_END_ERR;
        phase_nxt = lfd_pkg::PH_WAIT;
      end
      default: phase_nxt = lfd_pkg::PH_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lfd_pkg::PH_WAIT;
      module_r  <= 8'd0;
      length_r  <= 32'd0;
      len_cnt_r <= 2'd0;
      pay_cnt_r <= 8'd0;
      lrc_r     <= 8'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      module_r  <= module_nxt;
      length_r  <= length_nxt;
      len_cnt_r <= len_cnt_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      lrc_r     <= lrc_nxt;
    end
  end

  // module and length fields report the frame as it stands before this byte
  assign push_o.push                = accept & emit;
  assign push_o.result.out_kind     = kind;
  assign push_o.result.out_byte     = obyte;
  assign push_o.result.module_id    = module_r;
  assign push_o.result.frame_length = length_r;

endmodule

/* hw/rtl/lfd_out_queue.sv */
// lfd_out_queue: two-entry result register with skid slot
// depends on lfd_pkg
`timescale 1ns / 1ps

module lfd_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfd_pkg::push_t         push_i,
  input  logic                   pop,
  output logic                   valid,
  output lfd_pkg::result_t       head,
  output lfd_pkg::queue_status_t status
);

  logic [1:0]       count_r, count_nxt;
  lfd_pkg::result_t slot0_r, slot1_r;

  always_comb begin
    count_nxt = count_r;
    unique case ({push_i.push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // slot0 is the head; slot1 catches a result while the head is stalled
  always_ff @(posedge clk) begin
    unique case ({push_i.push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          slot0_r <= push_i.result;
        end else begin
          slot1_r <= push_i.result;
        end
      end
      2'b01: slot0_r <= slot1_r;
      2'b11: begin
        if (count_r == 2'd1) begin
          slot0_r <= push_i.result;
        end else begin
          slot0_r <= slot1_r;
          slot1_r <= push_i.result;
        end
      end
      default: ;
    endcase
  end

  assign valid        = (count_r != 2'd0);
  assign head         = slot0_r;
  assign status.count = count_r;
  assign status.full  = (count_r == 2'(lfd_pkg::QUEUE_DEPTH));

endmodule

/* hw/rtl/lrc_frame_deframer_top.sv */
// lrc_frame_deframer_top: head/tail frame parser with xor lrc, top level
// depends on lfd_pkg, lfd_stream_if, lfd_parser and lfd_out_queue
`timescale 1ns / 1ps

// One received byte is taken per item and one item can be accepted every clock cycle:
// the frame state (phase, module byte, length, counters, lrc) updates per accepted
// byte and any result it gives is registered in a two-entry output queue before it
// appears on out_ch. in_ch.ready drops only while both queue entries are full; the
// sustained rate of one item per cycle is set by the state update loop of the parser.
// Frames are head byte, module byte, 4-byte little-endian length, payload, xor lrc of
// the payload, tail byte. Payload bytes are forwarded as they arrive (kind 0); each
// frame that reaches its payload or lrc byte ends with one status item (ok, length
// error, check error, tail error), and the consumer must drop the forwarded payload
// unless the status is ok. Configuration registers (0 head value, 1 tail value, 2 max
// payload) are written through cfg_we/cfg_index/cfg_wdata by the user only while the
// block is idle, which the block does not enforce; index 3 is ignored.

module lrc_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  lfd_in_if.sink     in_ch,
  lfd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  lfd_pkg::cfg_t          cfg_r;
  lfd_pkg::push_t         push;
  lfd_pkg::result_t       head;
  lfd_pkg::queue_status_t qstat;
  logic                   accept;
  logic                   pop;
  logic                   q_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_value  <= lfd_pkg::HEAD_RESET;
      cfg_r.tail_value  <= lfd_pkg::TAIL_RESET;
      cfg_r.max_payload <= lfd_pkg::MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfd_pkg::REG_HEAD_VALUE:  cfg_r.head_value  <= cfg_wdata;
        lfd_pkg::REG_TAIL_VALUE:  cfg_r.tail_value  <= cfg_wdata;
        lfd_pkg::REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // take a byte whenever the queue has room for its result
  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && out_ch.ready;

  lfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_r),
    .push_o  (push)
  );

  lfd_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .valid  (q_valid),
    .head   (head),
    .status (qstat)
  );

  assign out_ch.valid        = q_valid;
  assign out_ch.out_kind     = head.out_kind;
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.module_id    = head.module_id;
  assign out_ch.frame_length = head.frame_length;

  // a result is only produced by an accepted byte
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> accept)
    else $error("result pushed without an accepted item");

  // queue never counts past its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= 2'(lfd_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

  // a full queue always offers a result
  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  // only payload items carry a nonzero byte
  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push && push.result.out_kind != lfd_pkg::KIND_DATA) |->
      (push.result.out_byte == 8'd0))
    else $error("status item with nonzero byte");

endmodule

/* verif/lrc_frame_deframer_top_tb.sv */
// lrc_frame_deframer_top_tb: self-checking bench for the head/tail frame parser with xor lrc
// depends on lfd_pkg, lfd_in_if/lfd_out_if and lrc_frame_deframer_top from hw/rtl
`timescale 1ns / 1ps

module lrc_frame_deframer_top_tb;

  // index 3 has no register behind it, writes there must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // spare clocks waited once no result is expected any more, to cover bytes with no result
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 370;
  localparam lfd_pkg::result_t NO_RES = '0;

  // one row of the directed table: byte to send and, where obvious, its result
  typedef struct packed {
    logic [7:0]       rx;
    logic             typed;
    lfd_pkg::result_t want;
  } stim_row_t;

  localparam int DIR_ROWS = 32;
  stim_row_t directed_rows [DIR_ROWS] = '{
    // zero-length frame goes straight to the lrc byte, then a good tail
    '{8'hA5, 1'b0, NO_RES}, '{8'h07, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h5A, 1'b1, '{lfd_pkg::KIND_OK, 8'h00, 8'h07, 32'd0}},
    // largest length field, rejected on the first payload byte
    '{8'hA5, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h3C, 1'b1, '{lfd_pkg::KIND_LEN_ERR, 8'h00, 8'hFF, 32'hFFFF_FFFF}},
    // one payload byte, good lrc, wrong tail
    '{8'hA5, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{lfd_pkg::KIND_DATA, 8'hFF, 8'h80, 32'd1}},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{lfd_pkg::KIND_END_ERR, 8'h00, 8'h80, 32'd1}},
    // zero-length frame with a bad lrc; the tail after it is a stray byte
    '{8'hA5, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h01, 1'b1, '{lfd_pkg::KIND_LRC_ERR, 8'h00, 8'h01, 32'd0}},
    '{8'h5A, 1'b0, NO_RES}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  lfd_in_if  in_if ();
  lfd_out_if out_if ();

  lrc_frame_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser mirror: settings and frame state as they stand after every accepted byte
  logic [7:0]  cfg_head = lfd_pkg::HEAD_RESET;
  logic [7:0]  cfg_tail = lfd_pkg::TAIL_RESET;
  logic [7:0]  cfg_max  = lfd_pkg::MAX_RESET;
  logic [2:0]  frm_phase = lfd_pkg::PH_WAIT;
  logic [7:0]  frm_module = 8'd0;
  logic [31:0] frm_length = 32'd0;
  logic [1:0]  len_idx = 2'd0;
  logic [7:0]  pay_count = 8'd0;
  logic [7:0]  lrc_sum = 8'd0;

  lfd_pkg::result_t expected_results [$];

  int bytes_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_done = 0;
  int kind_seen [5] = '{default: 0};
  int stall_left = 0;
  bit quiet = 1'b0;

  // advance the mirror by one byte; got says whether the byte gives a result
  task automatic parse_byte(input logic [7:0] b, output logic got,
                            output lfd_pkg::result_t r);
    got = 1'b0;
    r = '0;
    case (frm_phase)
      lfd_pkg::PH_WAIT: begin
        // anything but the head byte is dropped here
        if (b == cfg_head) begin
          frm_length = 32'd0;
          len_idx = 2'd0;
          pay_count = 8'd0;
          lrc_sum = 8'd0;
          frm_phase = lfd_pkg::PH_MODULE;
        end
      end
      lfd_pkg::PH_MODULE: begin
        frm_module = b;
        frm_phase = lfd_pkg::PH_LENGTH;
      end
      lfd_pkg::PH_LENGTH: begin
        // little-endian length, zero length skips the payload
        frm_length = frm_length | ({24'd0, b} << (8 * len_idx));
        if (len_idx == 2'd3) begin
          len_idx = 2'd0;
          frm_phase = (frm_length == 32'd0) ? lfd_pkg::PH_CHECK : lfd_pkg::PH_PAYLOAD;
        end else begin
          len_idx = len_idx + 2'd1;
        end
      end
      lfd_pkg::PH_PAYLOAD: begin
        got = 1'b1;
        if (pay_count == 8'd0 && frm_length > {24'd0, cfg_max}) begin
          // oversize frame: first payload byte swallowed, status only
          r.out_kind = lfd_pkg::KIND_LEN_ERR;
          frm_phase = lfd_pkg::PH_WAIT;
        end else begin
          lrc_sum = lrc_sum ^ b;
          r.out_kind = lfd_pkg::KIND_DATA;
          r.out_byte = b;
          if ({24'd0, pay_count} + 32'd1 >= frm_length) begin
            pay_count = 8'd0;
            frm_phase = lfd_pkg::PH_CHECK;
          end else begin
            pay_count = pay_count + 8'd1;
          end
        end
      end
      lfd_pkg::PH_CHECK: begin
        if (b != lrc_sum) begin
          got = 1'b1;
          r.out_kind = lfd_pkg::KIND_LRC_ERR;
          frm_phase = lfd_pkg::PH_WAIT;
        end else begin
          frm_phase = lfd_pkg::PH_TAIL;
        end
      end
      lfd_pkg::PH_TAIL: begin
        got = 1'b1;
        r.out_kind = (b == cfg_tail) ? lfd_pkg::KIND_OK : lfd_pkg::KIND_END_ERR;
        frm_phase = lfd_pkg::PH_WAIT;
      end
      default: frm_phase = lfd_pkg::PH_WAIT;
    endcase
    r.module_id = frm_module;
    r.frame_length = frm_length;
  endtask

  // offer one byte, wait for the handshake, then maybe leave a gap
  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input lfd_pkg::result_t want);
    logic             got;
    lfd_pkg::result_t r;
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
    parse_byte(b, got, r);
    if (typed) expected_results.push_back(want);
    else if (got) expected_results.push_back(r);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // stop feeding and let every pending result drain out
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      lfd_pkg::REG_HEAD_VALUE:  cfg_head = v;
      lfd_pkg::REG_TAIL_VALUE:  cfg_tail = v;
      lfd_pkg::REG_MAX_PAYLOAD: cfg_max = v;
      default: ;
    endcase
  endtask

  // registers change only once no result is pending; the unused index gets junk each time
  task automatic new_settings(input logic [7:0] h, input logic [7:0] t, input logic [7:0] m);
    wait_idle();
    set_reg(lfd_pkg::REG_HEAD_VALUE, h);
    set_reg(lfd_pkg::REG_TAIL_VALUE, t);
    set_reg(lfd_pkg::REG_MAX_PAYLOAD, m);
    set_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // one mostly well-formed frame with random content, sometimes noisy or cut short
  task automatic send_frame();
    logic [7:0]  fb [$];
    logic [31:0] len;
    logic [7:0]  lrc;
    logic [7:0]  b;
    int          pick;
    int          cut;
    fb = {};
    // stray bytes ahead of the head
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) len = $urandom();
    else if (pick < 13 && cfg_max != 8'hFF) len = {24'd0, cfg_max} + $urandom_range(1, 3);
    else if (pick == 13) len = {24'd0, cfg_max};
    else len = $urandom_range(0, 6);
    fb.push_back(cfg_head);
    fb.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) fb.push_back(len[8*i +: 8]);
    if (len > {24'd0, cfg_max}) begin
      // only the first payload byte matters once the length is too large
      fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      lrc = 8'd0;
      for (int unsigned i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        lrc = lrc ^ b;
        fb.push_back(b);
      end
      if ($urandom_range(0, 7) == 0) lrc = lrc ^ 8'($urandom_range(1, 255));
      fb.push_back(lrc);
      fb.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : cfg_tail);
    end
    // broken frame: drop its end so the next head lands mid-frame
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, fb.size() - 1);
      while (fb.size() > cut) void'(fb.pop_back());
    end
    foreach (fb[i]) push_byte(fb[i], 1'b0, NO_RES);
  endtask

  task automatic run_random(input int stop_at);
    while (bytes_sent < stop_at) send_frame();
  endtask

  // result side: compare each accepted item, then choose ready for the next cycle
  always @(posedge clk) begin : result_check
    lfd_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.out_kind <= lfd_pkg::KIND_END_ERR) kind_seen[out_if.out_kind]++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_kind %0d out_byte %0h", out_if.out_kind,
               out_if.out_byte);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0d, got %0d", want.out_kind, out_if.out_kind);
          mismatches++;
        end
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_if.out_byte);
          mismatches++;
        end
        if (out_if.module_id !== want.module_id) begin
          $error("module_id: expected %0h, got %0h", want.module_id, out_if.module_id);
          mismatches++;
        end
        if (out_if.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0h, got %0h", want.frame_length,
                 out_if.frame_length);
          mismatches++;
        end
      end
    end
    // random stall bursts, none in the quiet phase
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // main sequence: reset, directed table, then random phases under changing settings
  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= lfd_pkg::REG_HEAD_VALUE;
    cfg_wdata <= 8'd0;
    in_if.valid <= 1'b0;
    in_if.rx_byte <= 8'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: head 0xa5, tail 0x5a, max 255
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end
    run_random(bytes_sent + PHASE_BYTES);

    // extremes: zero head, all-ones tail, no payload allowed
    new_settings(8'h00, 8'hFF, 8'd0);
    run_random(bytes_sent + PHASE_BYTES);

    // opposite extremes
    new_settings(8'hFF, 8'h00, 8'd255);
    run_random(bytes_sent + PHASE_BYTES);

    // random markers with a small payload limit
    new_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(1, 16)));
    run_random(bytes_sent + PHASE_BYTES);

    // tail equal to head, full rate on both sides
    cfg_head = 8'($urandom_range(0, 255));
    new_settings(cfg_head, cfg_head, 8'($urandom_range(4, 255)));
    quiet = 1'b1;
    run_random(bytes_sent + PHASE_BYTES);

    wait_idle();
    repeat (20) @(posedge clk);

    $display("fed %0d bytes over %0d register settings, checked %0d results", bytes_sent,
             settings_done + 1, results_seen);
    $display("frame status: ok %0d, length error %0d, check error %0d, tail error %0d",
             kind_seen[lfd_pkg::KIND_OK], kind_seen[lfd_pkg::KIND_LEN_ERR],
             kind_seen[lfd_pkg::KIND_LRC_ERR], kind_seen[lfd_pkg::KIND_END_ERR]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $error("timeout with %0d results still expected", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
